FILE: hdl/uv_sphere_cell_tessellator_unit_defines.svh
// ----------------------------------------------------------------------------
// UV sphere cell tessellator assertion macros
// Shared concurrent assertion helpers for the tessellator RTL.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_CELL_TESSELLATOR_UNIT_DEFINES_SVH
`define UV_SPHERE_CELL_TESSELLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UVSCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uvsct assertion failed");

// Next-cycle implication, checked out of reset.
`define UVSCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uvsct assertion failed");

`endif

FILE: hdl/uvsct_pkg.sv
// ----------------------------------------------------------------------------
// UV sphere cell tessellator package
// Field widths, defaults and the quarter-wave Q1.15 sine table.
// ----------------------------------------------------------------------------
package uvsct_pkg;

  localparam int unsigned SLICE_W      = 7;
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned RADIUS_W     = 31;
  localparam int unsigned INDEX_W      = 6;
  localparam int unsigned PHASE_W      = 16;
  localparam int unsigned SINE_W       = 16;
  localparam int unsigned MAX_SLICES_DEF = 64;
  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned SINE_ADDR_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned SINE_IDX_W   = $clog2(SINE_TABLE_DEPTH);

  localparam logic [SLICE_W-1:0] SLICE_RESET   = 7'd16;
  localparam logic [PHASE_W-1:0] QUARTER_TURN  = 16'd16384;
  localparam logic [2:0]         LAST_VERTEX   = 3'd5;

  localparam logic [63:0] Q62_ONE     = 64'd1 << 62;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  // Q2.62 product, bits 125:62 of the full product
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Series term divide by (2k)(2k+1), one fixed divisor per term
  function automatic logic [63:0] series_div(input logic [63:0] v, input int k);
    case (k)
      12:      return v / 64'd600;
      11:      return v / 64'd506;
      10:      return v / 64'd420;
      9:       return v / 64'd342;
      8:       return v / 64'd272;
      7:       return v / 64'd210;
      6:       return v / 64'd156;
      5:       return v / 64'd110;
      4:       return v / 64'd72;
      3:       return v / 64'd42;
      2:       return v / 64'd20;
      default: return v / 64'd6;
    endcase
  endfunction

  // Series evaluation of sin over a quarter wave, rounded to Q1.15
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    q = HALF_PI_Q62 / SINE_TABLE_DEPTH;
    r = HALF_PI_Q62 % SINE_TABLE_DEPTH;
    for (int n = 0; n <= SINE_TABLE_DEPTH; n++) begin
      x  = q * 64'(n) + (r * 64'(n)) / SINE_TABLE_DEPTH;
      x2 = mul_q62(x, x);
      t  = Q62_ONE;
      for (int k = 12; k >= 1; k--) begin
        t  = Q62_ONE - series_div(mul_q62(x2, t), k);
      end
      v = (mul_q62(x, t) + (64'd1 << 46)) >> 47;
      if (v > 64'd32767) v = 64'd32767;
      tab[n] = v[SINE_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: hdl/uvsct_sine.sv
// ----------------------------------------------------------------------------
// UV sphere cell tessellator sine lookup
// Quarter-wave table lookup of a 16-bit turn phase, registered read.
// ----------------------------------------------------------------------------
module uvsct_sine
  import uvsct_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [PHASE_W-1:0]       phase_i,
  output logic signed [SINE_W-1:0] sine_o
);

  logic [1:0]                   quad;
  logic [14+SINE_ADDR_W-1:0]    idx_prod;
  logic [SINE_IDX_W-1:0]        idx;
  logic [SINE_ADDR_W-1:0]       addr;
  logic [SINE_W-1:0]            mag_q;
  logic                         neg_q;

  // Quadrant fold of the phase onto the table
  assign quad     = phase_i[15:14];
  assign idx_prod = (14+SINE_ADDR_W)'(phase_i[13:0]) * (14+SINE_ADDR_W)'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[14 +: SINE_IDX_W];
  assign addr     = quad[0] ? SINE_ADDR_W'(SINE_TABLE_DEPTH) - SINE_ADDR_W'(idx)
                            : SINE_ADDR_W'(idx);

  // Registered table read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= SINE_TAB[addr];
      neg_q <= quad[1];
    end
  end

  assign sine_o = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

FILE: hdl/uv_sphere_cell_tessellator_unit.sv
// ----------------------------------------------------------------------------
// UV sphere cell tessellator
// Turns one UV-sphere grid cell into its two triangles as six vertices.
// ----------------------------------------------------------------------------
// One cell item is taken and six vertex items follow, one per cycle unless
// vert_ready_i stalls, the sixth flagged by last_vertex_o. The single vertex
// output channel sets the sustained cell rate; the next cell is taken in
// the cycle the current cell issues its sixth vertex. An issued vertex passes
// phase multiply, table read, factor multiply, radius multiply, then round,
// add and saturate in the output register. The user must write the slice
// count through the cfg channel only while idle; the block does not enforce it.
`include "uv_sphere_cell_tessellator_unit_defines.svh"

module uv_sphere_cell_tessellator_unit
  import uvsct_pkg::*;
#(
  parameter int unsigned MAX_SLICES = MAX_SLICES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [SLICE_W-1:0]        cfg_data_i,
  // cell input
  input  logic                      cell_valid_i,
  output logic                      cell_ready_o,
  input  logic signed [COORD_W-1:0] center_x_i,
  input  logic signed [COORD_W-1:0] center_y_i,
  input  logic signed [COORD_W-1:0] center_z_i,
  input  logic [RADIUS_W-1:0]       sphere_radius_i,
  input  logic [INDEX_W-1:0]        band_index_i,
  input  logic [INDEX_W-1:0]        step_index_i,
  // vertex output
  output logic                      vert_valid_o,
  input  logic                      vert_ready_i,
  output logic signed [COORD_W-1:0] vert_x_o,
  output logic signed [COORD_W-1:0] vert_y_o,
  output logic signed [COORD_W-1:0] vert_z_o,
  output logic                      last_vertex_o
);

  localparam int unsigned SW  = $clog2(MAX_SLICES + 1);
  localparam int unsigned KB  = (SW + 2 > 7) ? SW + 2 : 7;
  localparam int unsigned KW  = KB + 1;
  localparam int unsigned RSH = 14 + KW + SW;
  localparam int unsigned PW  = KW + RSH + 1;

  // --------------------------------------------------------------------------
  // Configuration register and effective slice count
  // --------------------------------------------------------------------------
  logic [SLICE_W-1:0] slice_q;
  logic [SW-1:0]      s_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= SLICE_RESET;
    end else if (cfg_valid_i) begin
      slice_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (slice_q == '0) begin
      s_eff = SW'(1);
    end else if (32'(slice_q) > MAX_SLICES) begin
      s_eff = SW'(MAX_SLICES);
    end else begin
      s_eff = SW'(slice_q);
    end
  end

  // Reciprocal table: ceil(2^RSH / s)
  logic [RSH:0] recip_tab [0:MAX_SLICES];

  for (genvar gs = 0; gs <= MAX_SLICES; gs++) begin : g_recip
    if (gs == 0) begin : g_zero
      assign recip_tab[gs] = '0;
    end else begin : g_val
      localparam logic [63:0] RF = ((64'd1 << RSH) + 64'(gs) - 64'd1) / 64'(gs);
      assign recip_tab[gs] = RF[RSH:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables, back to front
  // --------------------------------------------------------------------------
  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q, out_valid_q;
  logic a_en, b_en, c_en, d_en, out_en;

  assign out_en = !out_valid_q || vert_ready_i;
  assign d_en   = !d_valid_q   || out_en;
  assign c_en   = !c_valid_q   || d_en;
  assign b_en   = !b_valid_q   || c_en;
  assign a_en   = !a_valid_q   || b_en;

  // --------------------------------------------------------------------------
  // Cell register and vertex sequencer
  // --------------------------------------------------------------------------
  logic                cell_valid_q;
  logic [2:0]          vtx_cnt_q;
  logic [COORD_W-1:0]  cx_q, cy_q, cz_q;
  logic [RADIUS_W-1:0] rad_q;
  logic [INDEX_W-1:0]  band_q, step_q;
  logic                issue;
  logic                cell_take;

  assign issue        = cell_valid_q && a_en;
  assign cell_ready_o = !cell_valid_q || (issue && vtx_cnt_q == LAST_VERTEX);
  assign cell_take    = cell_valid_i && cell_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_valid_q <= 1'b0;
      vtx_cnt_q    <= '0;
    end else if (cell_take) begin
      cell_valid_q <= 1'b1;
      vtx_cnt_q    <= '0;
    end else if (issue) begin
      if (vtx_cnt_q == LAST_VERTEX) begin
        cell_valid_q <= 1'b0;
      end else begin
        vtx_cnt_q <= vtx_cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_take) begin
      cx_q   <= center_x_i;
      cy_q   <= center_y_i;
      cz_q   <= center_z_i;
      rad_q  <= sphere_radius_i;
      band_q <= band_index_i;
      step_q <= step_index_i;
    end
  end

  // Vertex order (lon, lat): AL AH BH AL BH BL
  logic sel_lon, sel_lat;

  always_comb begin
    case (vtx_cnt_q)
      3'd0:    begin sel_lon = 1'b0; sel_lat = 1'b0; end
      3'd1:    begin sel_lon = 1'b0; sel_lat = 1'b1; end
      3'd2:    begin sel_lon = 1'b1; sel_lat = 1'b1; end
      3'd3:    begin sel_lon = 1'b0; sel_lat = 1'b0; end
      3'd4:    begin sel_lon = 1'b1; sel_lat = 1'b1; end
      3'd5:    begin sel_lon = 1'b1; sel_lat = 1'b0; end
      default: begin sel_lon = 1'b0; sel_lat = 1'b0; end
    endcase
  end

  // Angle steps in units of pi/(2s)
  logic [KW-1:0] k_lat, k_lon;

  assign k_lat = KW'({band_q, 1'b0}) + KW'({sel_lat, 1'b0}) + KW'(s_eff) * KW'(3);
  assign k_lon = KW'({step_q, 2'b00}) + KW'({sel_lon, 2'b00});

  // --------------------------------------------------------------------------
  // Stage A: phase = floor(k * 16384 / s) by reciprocal multiply
  // --------------------------------------------------------------------------
  logic [PW-1:0]       pl_prod_q, pg_prod_q;
  logic [COORD_W-1:0]  a_cx_q, a_cy_q, a_cz_q;
  logic [RADIUS_W-1:0] a_rad_q;
  logic                a_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_en) begin
      a_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      pl_prod_q <= PW'(k_lat) * PW'(recip_tab[s_eff]);
      pg_prod_q <= PW'(k_lon) * PW'(recip_tab[s_eff]);
      a_cx_q    <= cx_q;
      a_cy_q    <= cy_q;
      a_cz_q    <= cz_q;
      a_rad_q   <= rad_q;
      a_last_q  <= (vtx_cnt_q == LAST_VERTEX);
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: sine and cosine table reads
  // --------------------------------------------------------------------------
  logic [PHASE_W-1:0]       ph_lat, ph_lon;
  logic signed [SINE_W-1:0] sin_lat, cos_lat, sin_lon, cos_lon;
  logic [COORD_W-1:0]       b_cx_q, b_cy_q, b_cz_q;
  logic [RADIUS_W-1:0]      b_rad_q;
  logic                     b_last_q;

  assign ph_lat = pl_prod_q[RSH-14 +: PHASE_W];
  assign ph_lon = pg_prod_q[RSH-14 +: PHASE_W];

  uvsct_sine u_sin_lat (
    .clk_i, .en_i(b_en), .phase_i(ph_lat), .sine_o(sin_lat)
  );
  uvsct_sine u_cos_lat (
    .clk_i, .en_i(b_en), .phase_i(ph_lat + QUARTER_TURN), .sine_o(cos_lat)
  );
  uvsct_sine u_sin_lon (
    .clk_i, .en_i(b_en), .phase_i(ph_lon), .sine_o(sin_lon)
  );
  uvsct_sine u_cos_lon (
    .clk_i, .en_i(b_en), .phase_i(ph_lon + QUARTER_TURN), .sine_o(cos_lon)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_en) begin
      b_cx_q   <= a_cx_q;
      b_cy_q   <= a_cy_q;
      b_cz_q   <= a_cz_q;
      b_rad_q  <= a_rad_q;
      b_last_q <= a_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: Q2.30 direction factors
  // --------------------------------------------------------------------------
  logic signed [31:0]  fx_q, fy_q, fz_q;
  logic [COORD_W-1:0]  c_cx_q, c_cy_q, c_cz_q;
  logic [RADIUS_W-1:0] c_rad_q;
  logic                c_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_en) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_en) begin
      fx_q     <= 32'(cos_lon) * 32'(cos_lat);
      fy_q     <= 32'(sin_lon) * 32'(cos_lat);
      fz_q     <= {sin_lat[SINE_W-1], sin_lat, 15'd0};
      c_cx_q   <= b_cx_q;
      c_cy_q   <= b_cy_q;
      c_cz_q   <= b_cz_q;
      c_rad_q  <= b_rad_q;
      c_last_q <= b_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: radius times factor magnitude
  // --------------------------------------------------------------------------
  logic [31:0]        ax, ay, az;
  logic [61:0]        px_q, py_q, pz_q;
  logic               nx_q, ny_q, nz_q;
  logic [COORD_W-1:0] d_cx_q, d_cy_q, d_cz_q;
  logic               d_last_q;

  assign ax = fx_q[31] ? 32'(-fx_q) : 32'(fx_q);
  assign ay = fy_q[31] ? 32'(-fy_q) : 32'(fy_q);
  assign az = fz_q[31] ? 32'(-fz_q) : 32'(fz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (d_en) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_en) begin
      px_q     <= 62'(c_rad_q) * 62'(ax[30:0]);
      py_q     <= 62'(c_rad_q) * 62'(ay[30:0]);
      pz_q     <= 62'(c_rad_q) * 62'(az[30:0]);
      nx_q     <= fx_q[31];
      ny_q     <= fy_q[31];
      nz_q     <= fz_q[31];
      d_cx_q   <= c_cx_q;
      d_cy_q   <= c_cy_q;
      d_cz_q   <= c_cz_q;
      d_last_q <= c_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: round half away, add center, saturate
  // --------------------------------------------------------------------------
  function automatic logic [COORD_W-1:0] place(input logic [COORD_W-1:0] ctr,
                                               input logic [61:0] prod,
                                               input logic neg);
    logic [62:0] rnd;
    logic [34:0] off;
    logic [34:0] sum;
    rnd = {1'b0, prod} + 63'(64'd1 << 29);
    off = neg ? -35'(rnd[62:30]) : 35'(rnd[62:30]);
    sum = {{3{ctr[COORD_W-1]}}, ctr} + off;
    if (!sum[34] && sum[34:31] != 4'b0000) begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end else if (sum[34] && sum[34:31] != 4'b1111) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return sum[COORD_W-1:0];
    end
  endfunction

  logic [COORD_W-1:0] vx_q, vy_q, vz_q;
  logic               vlast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      vx_q    <= place(d_cx_q, px_q, nx_q);
      vy_q    <= place(d_cy_q, py_q, ny_q);
      vz_q    <= place(d_cz_q, pz_q, nz_q);
      vlast_q <= d_last_q;
    end
  end

  assign vert_valid_o  = out_valid_q;
  assign vert_x_o      = $signed(vx_q);
  assign vert_y_o      = $signed(vy_q);
  assign vert_z_o      = $signed(vz_q);
  assign last_vertex_o = vlast_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `UVSCT_ASSERT_IMP(a_ready_only_free, clk_i, rst_ni, cell_ready_o && cell_valid_q, issue && vtx_cnt_q == LAST_VERTEX)
  `UVSCT_ASSERT_NEXT(a_take_starts, clk_i, rst_ni, cell_take, cell_valid_q && vtx_cnt_q == 3'd0)
  `UVSCT_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, cell_valid_q, vtx_cnt_q <= LAST_VERTEX)

endmodule

FILE: tb/uvsct_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UV sphere tessellator checker
// Watches the config, cell and vertex channels, predicts the six vertices of
// every accepted cell and compares them in order with the vertex items.
// ----------------------------------------------------------------------------
module uvsct_checker
  import uvsct_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [SLICE_W-1:0]        cfg_data_i,
  input  logic                      cell_valid_i,
  input  logic                      cell_ready_i,
  input  logic signed [COORD_W-1:0] center_x_i,
  input  logic signed [COORD_W-1:0] center_y_i,
  input  logic signed [COORD_W-1:0] center_z_i,
  input  logic [RADIUS_W-1:0]       sphere_radius_i,
  input  logic [INDEX_W-1:0]        band_index_i,
  input  logic [INDEX_W-1:0]        step_index_i,
  input  logic                      vert_valid_i,
  input  logic                      vert_ready_i,
  input  logic signed [COORD_W-1:0] vert_x_i,
  input  logic signed [COORD_W-1:0] vert_y_i,
  input  logic signed [COORD_W-1:0] vert_z_i,
  input  logic                      last_vertex_i,
  output int                        pending_o,
  output int                        errors_o,
  output int                        vertices_o
);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } vertex_t;

  localparam int LUT_DEPTH = 1024;

  vertex_t               vertex_q[$];
  logic [15:0]           sine_lut [0:LUT_DEPTH];
  logic [SLICE_W-1:0]    slices;

  // Q2.62 multiply, keeping bits 125:62
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Quarter-wave table from a 12-term series, rounded to Q1.15
  initial begin
    logic [63:0] hp, q, r, x, x2, t, v;
    hp = 64'h6487_ED51_10B4_611A;
    q  = hp / LUT_DEPTH;
    r  = hp % LUT_DEPTH;
    for (int n = 0; n <= LUT_DEPTH; n++) begin
      x  = q * 64'(n) + (r * 64'(n)) / LUT_DEPTH;
      x2 = q62_mul(x, x);
      t  = 64'd1 << 62;
      for (int k = 12; k >= 1; k--)
        t = (64'd1 << 62) - q62_mul(x2, t) / 64'((2 * k) * (2 * k + 1));
      v = (q62_mul(x, t) + (64'd1 << 46)) >> 47;
      if (v > 64'd32767) v = 64'd32767;
      sine_lut[n] = v[15:0];
    end
  end

  function automatic logic [15:0] turn_phase(input int unsigned k, input int unsigned turn);
    return 16'(((k % turn) * 65536) / turn);
  endfunction

  function automatic longint lut_sine(input logic [15:0] ph);
    int unsigned idx;
    longint      mag;
    idx = ph[13:4];
    mag = ph[14] ? longint'(sine_lut[LUT_DEPTH - idx]) : longint'(sine_lut[idx]);
    return ph[15] ? -mag : mag;
  endfunction

  // radius times a Q2.30 factor, rounded half away from zero, plus center
  function automatic logic [31:0] place(input longint c, input logic [30:0] rad,
                                        input longint factor);
    logic [63:0] m, prod;
    longint      sum;
    m    = (factor < 0) ? 64'(-factor) : 64'(factor);
    prod = (64'(rad) * m + (64'd1 << 29)) >> 30;
    sum  = (factor < 0) ? c - longint'(prod) : c + longint'(prod);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  task automatic predict_cell_vertices();
    int unsigned s, turn;
    logic [15:0] pl, pg;
    longint      cos_lon[2], sin_lon[2], cos_lat[2], sin_lat[2];
    int          lon_sel[6], lat_sel[6];
    vertex_t     vx;
    lon_sel = '{0, 0, 1, 0, 1, 1};
    lat_sel = '{0, 1, 1, 0, 1, 0};
    s = (slices == 0) ? 1 : (slices > 64) ? 64 : slices;
    turn = 4 * s;
    for (int v = 0; v < 2; v++) begin
      pl = turn_phase(2 * band_index_i + 2 * v + 3 * s, turn);
      pg = turn_phase(4 * step_index_i + 4 * v, turn);
      sin_lat[v] = lut_sine(pl);
      cos_lat[v] = lut_sine(pl + QUARTER_TURN);
      sin_lon[v] = lut_sine(pg);
      cos_lon[v] = lut_sine(pg + QUARTER_TURN);
    end
    for (int v = 0; v < 6; v++) begin
      vx.x = place(center_x_i, sphere_radius_i, cos_lon[lon_sel[v]] * cos_lat[lat_sel[v]]);
      vx.y = place(center_y_i, sphere_radius_i, sin_lon[lon_sel[v]] * cos_lat[lat_sel[v]]);
      vx.z = place(center_z_i, sphere_radius_i, sin_lat[lat_sel[v]] * 32768);
      vx.last = (v == 5);
      vertex_q = {vertex_q, vx};
    end
  endtask

  // Track slice count, queue predictions, compare vertices
  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t want;
    if (!rst_ni) begin
      slices = SLICE_RESET;
      vertex_q.delete();
      errors_o   = 0;
      vertices_o = 0;
      pending_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) slices = cfg_data_i;
      if (cell_valid_i && cell_ready_i) predict_cell_vertices();
      if (vert_valid_i && vert_ready_i) begin
        vertices_o++;
        if (vertex_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: unexpected vertex x=%h y=%h z=%h last=%b", $realtime,
                     vert_x_i, vert_y_i, vert_z_i, last_vertex_i);
        end else begin
          want = vertex_q.pop_front();
          if (want.x !== vert_x_i || want.y !== vert_y_i || want.z !== vert_z_i ||
              want.last !== last_vertex_i) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: vertex mismatch exp x=%h y=%h z=%h last=%b, got x=%h y=%h z=%h last=%b",
                       $realtime, want.x, want.y, want.z, want.last,
                       vert_x_i, vert_y_i, vert_z_i, last_vertex_i);
          end
        end
      end
      pending_o = vertex_q.size();
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UV sphere tessellator testbench
// Drives directed and random cells over several slice counts with random
// idling on both sides; the checker predicts and compares every vertex.
// ----------------------------------------------------------------------------
module testbench;
  import uvsct_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 12;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [SLICE_W-1:0]        cfg_data = '0;
  logic                      cell_valid = 1'b0;
  logic                      cell_ready;
  logic signed [COORD_W-1:0] center_x = '0, center_y = '0, center_z = '0;
  logic [RADIUS_W-1:0]       radius = '0;
  logic [INDEX_W-1:0]        band = '0, step = '0;
  logic                      vert_valid;
  logic                      vert_ready = 1'b0;
  logic signed [COORD_W-1:0] vert_x, vert_y, vert_z;
  logic                      vert_last;

  int pending, errors, vertices;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int stall_req = 0, stall_seen = 0, stall_left = 0;
  int quiet_cycles = 0, cells = 0;

  always #10 clk_i = ~clk_i;

  uv_sphere_cell_tessellator_unit i_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .cell_valid_i(cell_valid), .cell_ready_o(cell_ready),
    .center_x_i(center_x), .center_y_i(center_y), .center_z_i(center_z),
    .sphere_radius_i(radius), .band_index_i(band), .step_index_i(step),
    .vert_valid_o(vert_valid), .vert_ready_i(vert_ready),
    .vert_x_o(vert_x), .vert_y_o(vert_y), .vert_z_o(vert_z),
    .last_vertex_o(vert_last)
  );

  uvsct_checker i_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .cell_valid_i(cell_valid), .cell_ready_i(cell_ready),
    .center_x_i(center_x), .center_y_i(center_y), .center_z_i(center_z),
    .sphere_radius_i(radius), .band_index_i(band), .step_index_i(step),
    .vert_valid_i(vert_valid), .vert_ready_i(vert_ready),
    .vert_x_i(vert_x), .vert_y_i(vert_y), .vert_z_i(vert_z),
    .last_vertex_i(vert_last),
    .pending_o(pending), .errors_o(errors), .vertices_o(vertices)
  );

  // Vertex receiver: random idling, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      vert_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_seen != stall_req) begin
      vert_ready <= 1'b0;
      stall_seen <= stall_req;
      stall_left <= 200;
    end else begin
      vert_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no accepted item anywhere
  always @(posedge clk_i) begin
    if ((cfg_valid && cfg_ready) || (cell_valid && cell_ready) || (vert_valid && vert_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_cell(input logic [31:0] cx, input logic [31:0] cy,
                           input logic [31:0] cz, input logic [30:0] r,
                           input logic [5:0] b, input logic [5:0] j);
    if ($urandom_range(99) < send_idle_pct) begin
      cell_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    cell_valid <= 1'b1;
    center_x <= cx; center_y <= cy; center_z <= cz;
    radius <= r; band <= b; step <= j;
    @(posedge clk_i);
    while (!cell_ready) @(posedge clk_i);
    cells++;
  endtask

  // Let the block drain, then write the slice count
  task automatic set_slices(input logic [SLICE_W-1:0] value);
    cell_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Random cell; indices mostly inside the grid, radii mostly moderate
  task automatic send_random_cell(input int unsigned s);
    logic [5:0]  b, j;
    logic [30:0] r;
    s = (s == 0) ? 1 : (s > 64) ? 64 : s;
    if ($urandom_range(9) == 0) begin
      b = 6'($urandom); j = 6'($urandom);
    end else begin
      b = 6'($urandom_range(s - 1)); j = 6'($urandom_range(s - 1));
    end
    r = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(32'h00FF_FFFF));
    send_cell($urandom, $urandom, $urandom, r, b, j);
  endtask

  initial begin
    logic [SLICE_W-1:0] slice_set [6];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cells at the reset slice count
    send_cell(0, 0, 0, 0, 0, 0);
    send_cell(0, 0, 0, 31'h0001_0000, 0, 0);
    send_cell(0, 0, 0, 31'h7FFF_FFFF, 15, 15);
    send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 8, 3);
    send_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 2, 11);
    send_cell(32'hFFFF_0000, 32'h0001_0000, 32'h8000_0001, 31'h0040_0000, 7, 8);
    send_cell(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 31'h0010_0000, 63, 63);
    send_cell(0, 0, 0, 31'h0010_0000, 16, 40);
    send_cell(0, 0, 0, 31'h5555_5555, 42, 21);
    // long receiver hold-off while cells keep coming
    stall_req++;
    for (int i = 0; i < 6; i++) send_random_cell(16);
    // sender waits for every vertex before going on
    cell_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    // Slice extremes, zero and overrange
    set_slices(1);
    send_cell(32'h0000_1000, 0, 0, 31'h0002_0000, 0, 0);
    send_cell(0, 0, 0, 31'h0002_0000, 5, 9);
    set_slices(64);
    send_cell(0, 0, 0, 31'h0100_0000, 0, 63);
    send_cell(0, 0, 0, 31'h0100_0000, 63, 0);
    set_slices(0);
    send_cell(0, 0, 0, 31'h0100_0000, 0, 0);
    set_slices(127);
    send_cell(0, 0, 0, 31'h0100_0000, 31, 32);

    // Random part: three idling regimes over several slice counts
    slice_set = '{7'd3, 7'd64, 7'd1, 7'd16, 7'd127, 7'd0};
    for (int p = 0; p < 6; p++) begin
      set_slices((p == 5) ? 7'($urandom_range(2, 63)) : slice_set[p]);
      send_idle_pct = (p < 2) ? 11 : (p < 4) ? 85 : 0;
      recv_idle_pct = (p < 2) ? 85 : (p < 4) ? 11 : 0;
      if (p == 4) stall_req++;
      for (int i = 0; i < 22; i++) send_random_cell(slice_set[p] == 0 ? 1 : slice_set[p]);
    end
    cell_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d cells and %0d vertices over slice counts 0..127,", cells, vertices);
    $display("with saturating centers, extreme radii and out-of-grid indices.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: uv_sphere_cell_tessellator_unit.f
+incdir+hdl
hdl/uvsct_pkg.sv
hdl/uvsct_sine.sv
hdl/uv_sphere_cell_tessellator_unit.sv
tb/uvsct_checker.sv
tb/testbench.sv
